FILE: design/wllr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllr_pkg: shared types and constants for the weighted log-loss reduction
// Holds formats, mode codes, and the word passed from front to back.
// ----------------------------------------------------------------------------
package wllr_pkg;

  localparam int COUNT_BITS = 20;
  localparam int ACC_BITS   = 56;
  localparam int WACC_BITS  = 40;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int LOG_FRAC   = 28;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [31:0] LOG_MIN_Q24 = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_WMEAN = 2'd2,
    MODE_NZMEAN = 2'd3
  } mode_t;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_EPS  = 1'b1;

  // element loss word from front end to back end
  typedef struct packed {
    logic signed [63:0] elem;   // Q16.16 unsaturated element loss
    logic signed [15:0] weight;
    logic               last;
    mode_t              mode;
  } elem_word_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_LOG1, FE_LOG2, FE_MUL, FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE, BE_DIV, BE_OUT
  } be_state_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

FILE: design/weighted_log_loss_reduce_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_log_loss_reduce_top: weighted log loss with streaming reduction
// Front end computes the element loss, back end accumulates and reduces.
// ----------------------------------------------------------------------------
// Each element passes two iterative log passes, the product steps, push and
// pop; reductions in modes 2 and 3 add a bit-serial divide on the last
// element. The front end takes no new element until the current one is
// pushed, as the squaring log unit is shared; output stalls back up
// through the two-entry queue into the front end.
// Reset: synchronous active-low; clears accumulators, mode to 0, epsilon to 2.
module weighted_log_loss_reduce_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // prediction[15:0], label[31:16], weight[47:32]
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // loss_value[31:0]
  output logic        out_tlast,  // final_result
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [1:0] mode_r;
  logic [15:0] eps_r;
  logic push, pop, q_full, q_ne;
  wllr_pkg::elem_word_t push_word, head_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      eps_r <= 16'd2;
    end else if (cfg_we) begin
      if (cfg_addr == wllr_pkg::REG_MODE) mode_r <= cfg_wdata[1:0];
      else if (cfg_addr == wllr_pkg::REG_EPS) eps_r <= cfg_wdata;
    end
  end

  wllr_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .prediction(in_tdata[15:0]), .label(in_tdata[31:16]),
    .weight($signed(in_tdata[47:32])), .last_element(in_tlast),
    .mode(mode_r), .epsilon(eps_r),
    .push, .push_word, .q_full
  );

  wllr_queue u_queue (
    .clk, .rst_n, .push, .push_word, .full(q_full),
    .pop, .not_empty(q_ne), .head_word
  );

  wllr_back u_back (
    .clk, .rst_n, .not_empty(q_ne), .head_word, .pop,
    .out_tvalid, .out_tready,
    .loss_value(out_tdata), .final_result(out_tlast)
  );

endmodule

FILE: design/wllr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllr_front: element loss front end
// Computes both logs with one iterative squaring unit, then the weighted loss.
// ----------------------------------------------------------------------------
module wllr_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              prediction,
  input  logic [15:0]              label,
  input  logic signed [15:0]       weight,
  input  logic                     last_element,
  input  logic [1:0]               mode,
  input  logic [15:0]              epsilon,
  output logic                     push,
  output wllr_pkg::elem_word_t     push_word,
  input  logic                     q_full
);

  wllr_pkg::fe_state_t state_r, state_nxt;
  logic [15:0] p_r, y_r;
  logic signed [15:0] w_r;
  logic last_r;
  logic [1:0] mode_r;
  logic [15:0] eps_r;
  logic signed [31:0] l1_r;
  logic signed [31:0] l2_r;
  // log unit
  logic [31:0] z_r, z_nxt;
  logic signed [35:0] lg_r, lg_nxt;
  logic [4:0] it_r, it_nxt;
  logic started_r, started_nxt;
  logic clamp_r, clamp_nxt;
  logic signed [63:0] prod_r;
  logic signed [63:0] e39_r;
  logic [1:0] mstep_r, mstep_nxt;

  logic signed [27:0] arg;
  logic [26:0] uarg;
  logic [4:0] msb;
  logic [61:0] sq;
  logic [31:0] zsq;
  logic signed [63:0] lnprod;
  logic signed [31:0] ln_res;
  logic signed [63:0] e39_nxt;
  logic signed [63:0] elem_calc;

  assign in_ready = (state_r == wllr_pkg::FE_IDLE);

  // log argument select
  always_comb begin
    if (state_r == wllr_pkg::FE_LOG1)
      arg = $signed({3'b0, p_r, 9'b0}) + $signed({12'b0, eps_r});
    else
      arg = 28'sd16777216 + $signed({12'b0, eps_r}) - $signed({3'b0, p_r, 9'b0});
    uarg = arg[26:0];
    msb = 5'd0;
    for (int i = 0; i < 27; i++)
      if (uarg[i]) msb = 5'(i);
  end

  assign sq  = 62'(z_r[30:0]) * 62'(z_r[30:0]);
  assign zsq = 32'(sq >> 30);
  assign lnprod = 64'(lg_r) * $signed({34'b0, wllr_pkg::LN2_Q30}) + (64'sd1 <<< 33);
  assign ln_res = clamp_r ? $signed(wllr_pkg::LOG_MIN_Q24) : 32'(lnprod >>> 34);

  always_comb begin
    state_nxt = state_r;
    z_nxt = z_r; lg_nxt = lg_r; it_nxt = it_r;
    started_nxt = started_r; clamp_nxt = clamp_r;
    mstep_nxt = mstep_r;
    push = 1'b0;
    case (state_r)
      wllr_pkg::FE_IDLE: begin
        if (in_valid) begin
          state_nxt = wllr_pkg::FE_LOG1;
          started_nxt = 1'b0;
        end
      end
      wllr_pkg::FE_LOG1, wllr_pkg::FE_LOG2: begin
        if (!started_r) begin
          clamp_nxt = (arg <= 0);
          z_nxt = 32'({uarg, 30'b0} >> msb);
          lg_nxt = 36'(($signed({31'b0, msb}) - 36'sd24) <<< wllr_pkg::LOG_FRAC);
          it_nxt = 5'd0;
          started_nxt = 1'b1;
        end else if (it_r != 5'(wllr_pkg::LOG_FRAC)) begin
          if (zsq[31]) begin
            z_nxt = zsq >> 1;
            lg_nxt = lg_r + (36'sd1 <<< (5'd27 - it_r));
          end else begin
            z_nxt = zsq;
          end
          it_nxt = it_r + 5'd1;
        end else begin
          started_nxt = 1'b0;
          if (state_r == wllr_pkg::FE_LOG1) state_nxt = wllr_pkg::FE_LOG2;
          else begin
            state_nxt = wllr_pkg::FE_MUL;
            mstep_nxt = 2'd0;
          end
        end
      end
      wllr_pkg::FE_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) state_nxt = wllr_pkg::FE_PUSH;
      end
      wllr_pkg::FE_PUSH: begin
        if (!q_full) begin
          push = 1'b1;
          state_nxt = wllr_pkg::FE_IDLE;
        end
      end
      default: state_nxt = wllr_pkg::FE_IDLE;
    endcase
  end

  // products, one multiply per cycle
  always_comb begin
    case (mstep_r)
      2'd0: e39_nxt = -($signed({48'b0, y_r}) * 64'(l1_r));
      2'd1: e39_nxt = e39_r - (($signed(64'sd32768) - $signed({48'b0, y_r})) * 64'(l2_r));
      default: e39_nxt = e39_r;
    endcase
  end
  assign elem_calc = (prod_r + (64'sd1 <<< 30)) >>> 31;

  assign push_word.elem = elem_calc;
  assign push_word.weight = w_r;
  assign push_word.last = last_r;
  assign push_word.mode = wllr_pkg::mode_t'(mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wllr_pkg::FE_IDLE;
      started_r <= 1'b0;
      mstep_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      mstep_r <= mstep_nxt;
    end
    z_r <= z_nxt; lg_r <= lg_nxt; it_r <= it_nxt; clamp_r <= clamp_nxt;
    if (state_r == wllr_pkg::FE_IDLE && in_valid) begin
      p_r <= prediction; y_r <= label; w_r <= weight;
      last_r <= last_element; mode_r <= mode; eps_r <= epsilon;
    end
    if (started_r && it_r == 5'(wllr_pkg::LOG_FRAC)) begin
      if (state_r == wllr_pkg::FE_LOG1) l1_r <= ln_res;
      else l2_r <= ln_res;
    end
    if (state_r == wllr_pkg::FE_MUL) begin
      e39_r <= e39_nxt;
      if (mstep_r == 2'd2) prod_r <= e39_r * 64'(w_r);
    end
  end

endmodule

FILE: design/wllr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllr_queue: two-entry queue between front and back end
// Lets each side stall on its own.
// ----------------------------------------------------------------------------
module wllr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wllr_pkg::elem_word_t push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output wllr_pkg::elem_word_t head_word
);

  wllr_pkg::elem_word_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_word;
  end

endmodule

FILE: design/wllr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wllr_back: accumulation and reduction back end
// Saturating accumulators, a restoring divider, and the output register.
// ----------------------------------------------------------------------------
module wllr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 not_empty,
  input  wllr_pkg::elem_word_t head_word,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          loss_value,
  output logic                 final_result
);

  localparam logic signed [63:0] ACC_HI = 64'sd2 ** (wllr_pkg::ACC_BITS - 1) - 64'sd1;
  localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;
  localparam logic signed [63:0] WACC_HI = 64'sd2 ** (wllr_pkg::WACC_BITS - 1) - 64'sd1;
  localparam logic signed [63:0] WACC_LO = -WACC_HI - 64'sd1;
  localparam logic [wllr_pkg::CNT_W-1:0] CNT_MAX = '1;

  wllr_pkg::be_state_t state_r, state_nxt;
  logic signed [63:0] acc_r, wacc_r;
  logic [wllr_pkg::CNT_W-1:0] cnt_r;
  logic [31:0] res_r;
  logic fin_r;
  logic neg_r;
  logic [63:0] num_r, den_r, rem_r, q_r;
  logic [6:0] bit_r;

  logic signed [63:0] acc_new, wacc_new;
  logic [wllr_pkg::CNT_W-1:0] cnt_new;
  logic signed [63:0] e, w;
  logic [64:0] rem_sh;
  logic [63:0] un, ud;
  logic [6:0] nbits;
  logic [63:0] mag;

  assign e = head_word.elem;
  assign w = 64'(head_word.weight);

  // saturating adds
  always_comb begin
    if (e > 0 && acc_r > ACC_HI - e) acc_new = ACC_HI;
    else if (e < 0 && acc_r < ACC_LO - e) acc_new = ACC_LO;
    else acc_new = acc_r + e;
    if (w > 0 && wacc_r > WACC_HI - w) wacc_new = WACC_HI;
    else if (w < 0 && wacc_r < WACC_LO - w) wacc_new = WACC_LO;
    else wacc_new = wacc_r + w;
    cnt_new = (head_word.weight != 0 && cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  end

  assign un = acc_new[63] ? 64'(-acc_new) : 64'(acc_new);
  assign ud = (head_word.mode == wllr_pkg::MODE_WMEAN)
              ? (wacc_new[63] ? 64'(-wacc_new) : 64'(wacc_new)) : 64'(cnt_new);
  assign nbits = (head_word.mode == wllr_pkg::MODE_WMEAN) ? 7'd73 : 7'd65;
  assign rem_sh = {rem_r, num_r[63]};
  // rounded magnitude; a saturated quotient maps to a value far past 32 bits
  assign mag = q_r[63] ? (64'd1 << 40) : ((q_r + 64'd1) >> 1);

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      wllr_pkg::BE_IDLE: begin
        if (not_empty) begin
          pop = 1'b1;
          if (head_word.mode == wllr_pkg::MODE_NONE || head_word.mode == wllr_pkg::MODE_SUM
              || !head_word.last) begin
            if (head_word.mode == wllr_pkg::MODE_NONE || head_word.last)
              state_nxt = wllr_pkg::BE_OUT;
          end else if (ud == 64'd0) state_nxt = wllr_pkg::BE_OUT;
          else state_nxt = wllr_pkg::BE_DIV;
        end
      end
      wllr_pkg::BE_DIV: if (bit_r == 7'd0) state_nxt = wllr_pkg::BE_OUT;
      wllr_pkg::BE_OUT: if (out_tready) state_nxt = wllr_pkg::BE_IDLE;
      default: state_nxt = wllr_pkg::BE_IDLE;
    endcase
  end

  assign out_tvalid = (state_r == wllr_pkg::BE_OUT);
  assign loss_value = res_r;
  assign final_result = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wllr_pkg::BE_IDLE;
      acc_r <= '0; wacc_r <= '0; cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        if (head_word.last) begin
          acc_r <= '0; wacc_r <= '0; cnt_r <= '0;
        end else begin
          acc_r <= acc_new; wacc_r <= wacc_new; cnt_r <= cnt_new;
        end
      end
    end
    if (pop) begin
      fin_r <= head_word.last;
      neg_r <= acc_new[63] ^ ((head_word.mode == wllr_pkg::MODE_WMEAN) && wacc_new[63]);
      num_r <= un; den_r <= ud; rem_r <= '0; q_r <= '0;
      // bits: 64 integer + 8 frac + 1 round (mode 2) or 64 + 1
      bit_r <= nbits;
      if (head_word.mode == wllr_pkg::MODE_NONE) res_r <= wllr_pkg::sat32(e);
      else if (head_word.mode == wllr_pkg::MODE_SUM) res_r <= wllr_pkg::sat32(acc_new);
      else res_r <= '0;
    end
    // long division, one quotient bit per cycle; numerator shifted in then zeros
    if (state_r == wllr_pkg::BE_DIV) begin
      if (bit_r != 7'd0) begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= 64'(rem_sh - {1'b0, den_r});
          q_r <= (q_r[63:62] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          q_r <= (q_r[63:62] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : {q_r[62:0], 1'b0};
        end
        bit_r <= bit_r - 7'd1;
      end else begin
        res_r <= wllr_pkg::sat32(neg_r ? -$signed(mag) : $signed(mag));
      end
    end
  end

endmodule
